FILE: rtl/b1s1_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b1s1_pkg;

    localparam int DEF_GRID_WIDTH  = 128;
    localparam int DEF_GRID_HEIGHT = 64;

    localparam int CMD_W = 2;
    localparam int COL_W = 7;
    localparam int ROW_W = 6;

    typedef logic [CMD_W-1:0] cmd_t;

    localparam cmd_t CMD_CLEAR = 2'd0;
    localparam cmd_t CMD_WRITE = 2'd1;
    localparam cmd_t CMD_READ  = 2'd2;
    localparam cmd_t CMD_GEN   = 2'd3;

endpackage

`default_nettype wire

FILE: rtl/b1s1_plane_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module b1s1_plane_ram #(
    parameter int DEPTH = 8192,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic              wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic                   rdata
);

    logic mem [DEPTH];
    logic rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/b1s1_gen_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module b1s1_gen_engine #(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 64,
    localparam int ADDR_W = $clog2(GRID_WIDTH * GRID_HEIGHT)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              go,
    input  wire logic              clr_mode,
    input  wire logic              src_rdata,
    output logic [ADDR_W-1:0]      rd_addr,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output logic                   wr_data,
    output logic                   done
);

    localparam int CELL_N = GRID_WIDTH * GRID_HEIGHT;
    localparam int CW     = $clog2(GRID_WIDTH);
    localparam int RW     = $clog2(GRID_HEIGHT);
    localparam int WIN    = 2 * GRID_HEIGHT + 3;

    localparam logic [ADDR_W-1:0] LAST_K   = ADDR_W'(CELL_N - 1);
    localparam logic [ADDR_W-1:0] CTR_OFFS = ADDR_W'(GRID_HEIGHT + 1);
    localparam logic [RW-1:0]     LAST_R   = RW'(GRID_HEIGHT - 1);
    localparam logic [RW-1:0]     MIN_R    = RW'(2);
    localparam logic [CW-1:0]     MIN_C    = CW'(2);

    logic              run_reg, run_next;
    logic              clr_reg, clr_next;
    logic [ADDR_W-1:0] k0_reg, k0_next;
    logic [CW-1:0]     c0_reg, c0_next;
    logic [RW-1:0]     r0_reg, r0_next;

    logic              v1_reg, v2_reg;
    logic [ADDR_W-1:0] k1_reg, k2_reg;
    logic [CW-1:0]     c1_reg, c2_reg;
    logic [RW-1:0]     r1_reg, r2_reg;

    logic [WIN-1:0]    win_reg;
    logic [7:0]        nbr;
    logic [3:0]        nbr_cnt;
    logic              last0;
    logic              interior;

    assign last0 = (k0_reg == LAST_K);

    always_comb
    begin
        run_next = run_reg;
        clr_next = clr_reg;
        k0_next  = k0_reg;
        c0_next  = c0_reg;
        r0_next  = r0_reg;
        if (go)
        begin
            run_next = 1'b1;
            clr_next = clr_mode;
            k0_next  = '0;
            c0_next  = '0;
            r0_next  = '0;
        end
        else if (run_reg)
        begin
            if (last0)
            begin
                run_next = 1'b0;
            end
            k0_next = k0_reg + ADDR_W'(1);
            if (r0_reg == LAST_R)
            begin
                r0_next = '0;
                c0_next = c0_reg + CW'(1);
            end
            else
            begin
                r0_next = r0_reg + RW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            clr_reg <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            clr_reg <= clr_next;
            v1_reg  <= run_reg & ~clr_reg;
            v2_reg  <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        k0_reg <= k0_next;
        c0_reg <= c0_next;
        r0_reg <= r0_next;
        k1_reg <= k0_reg;
        c1_reg <= c0_reg;
        r1_reg <= r0_reg;
        k2_reg <= k1_reg;
        c2_reg <= c1_reg;
        r2_reg <= r1_reg;
        if (v1_reg)
        begin
            win_reg <= {win_reg[WIN-2:0], src_rdata};
        end
    end

    // window: tap 0 is the newest cell, tap GRID_HEIGHT+1 the center
    assign nbr = {win_reg[0], win_reg[1], win_reg[2],
                  win_reg[GRID_HEIGHT], win_reg[GRID_HEIGHT + 2],
                  win_reg[2 * GRID_HEIGHT], win_reg[2 * GRID_HEIGHT + 1],
                  win_reg[2 * GRID_HEIGHT + 2]};

    always_comb
    begin
        nbr_cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            nbr_cnt = nbr_cnt + 4'(nbr[i]);
        end
    end

    assign interior = (r2_reg >= MIN_R) && (c2_reg >= MIN_C);

    assign rd_addr = k0_reg;
    assign wr_en   = (run_reg & clr_reg) | (v2_reg & interior);
    assign wr_addr = clr_reg ? k0_reg : (k2_reg - CTR_OFFS);
    assign wr_data = ~clr_reg & (nbr_cnt == 4'd1);
    assign done    = (run_reg & clr_reg & last0) | (v2_reg & (k2_reg == LAST_K));

endmodule

`default_nettype wire

FILE: rtl/b1s1_cellular_automaton_step.sv
// Simple commands (write, read cell): result in the cycle after accept, busy stays low.
// Clear and generation sweep the grid one cell per cycle; generation reads
// through the single read port of the source plane memory.
// busy is high while a clear or generation sweep runs; no item is taken then.
// Each result is shown for one cycle on done; the receiver cannot stall.
// After reset both planes are cleared with busy high.
`timescale 1ns / 1ps
`default_nettype none

module b1s1_cellular_automaton_step #(
    parameter int GRID_WIDTH  = b1s1_pkg::DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = b1s1_pkg::DEF_GRID_HEIGHT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [b1s1_pkg::CMD_W-1:0]  cmd,
    input  wire logic [b1s1_pkg::COL_W-1:0]  col,
    input  wire logic [b1s1_pkg::ROW_W-1:0]  row,
    input  wire logic                        cell_in,
    output logic                             busy,
    output logic                             done,
    output logic                             cell_out,
    output logic [b1s1_pkg::CMD_W-1:0]       done_cmd
);

    import b1s1_pkg::*;

    localparam int ADDR_W = $clog2(GRID_WIDTH * GRID_HEIGHT);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_INIT  = 2'd1;
    localparam logic [1:0] ST_BOOT  = 2'd2;
    localparam logic [1:0] ST_SWEEP = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic              cur_b_reg, cur_b_next;
    cmd_t              sweep_cmd_reg, sweep_cmd_next;
    logic              done_reg, done_next;
    cmd_t              done_cmd_reg, done_cmd_next;
    logic              rd_pend_reg, rd_pend_next;

    logic              fire;
    logic              in_grid;
    logic [ADDR_W-1:0] cmd_addr;
    logic              eng_go;
    logic              eng_clr;
    logic              eng_clr_on;
    logic              eng_done;
    logic [ADDR_W-1:0] eng_raddr;
    logic              eng_we;
    logic [ADDR_W-1:0] eng_waddr;
    logic              eng_wdata;
    logic              src_rdata;
    logic              rd_a;
    logic              rd_b;
    logic              cmd_we;
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
    logic [ADDR_W-1:0] raddr;

    assign busy    = (state_reg != ST_IDLE);
    assign fire    = start & ~busy;
    assign in_grid = (int'(col) < GRID_WIDTH) && (int'(row) < GRID_HEIGHT);
    assign cmd_addr = ADDR_W'(col) * ADDR_W'(GRID_HEIGHT) + ADDR_W'(row);

    assign eng_go  = (state_reg == ST_INIT) |
                     (fire & ((cmd == CMD_CLEAR) || (cmd == CMD_GEN)));
    assign eng_clr = (state_reg == ST_INIT) | (cmd == CMD_CLEAR);

    always_comb
    begin
        state_next     = state_reg;
        cur_b_next     = cur_b_reg;
        sweep_cmd_next = sweep_cmd_reg;
        done_next      = 1'b0;
        done_cmd_next  = done_cmd_reg;
        rd_pend_next   = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                state_next = ST_BOOT;
            end
            ST_BOOT:
            begin
                if (eng_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (eng_done)
                begin
                    state_next    = ST_IDLE;
                    done_next     = 1'b1;
                    done_cmd_next = sweep_cmd_reg;
                    if (sweep_cmd_reg == CMD_GEN)
                    begin
                        cur_b_next = ~cur_b_reg;
                    end
                end
            end
            default:
            begin
                if (fire)
                begin
                    unique case (cmd)
                        CMD_WRITE, CMD_READ:
                        begin
                            done_next     = 1'b1;
                            done_cmd_next = cmd;
                            rd_pend_next  = (cmd == CMD_READ) & in_grid;
                        end
                        default:
                        begin
                            state_next     = ST_SWEEP;
                            sweep_cmd_next = cmd;
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cur_b_reg     <= 1'b0;
            sweep_cmd_reg <= CMD_CLEAR;
            done_reg      <= 1'b0;
            done_cmd_reg  <= CMD_CLEAR;
            rd_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_b_reg     <= cur_b_next;
            sweep_cmd_reg <= sweep_cmd_next;
            done_reg      <= done_next;
            done_cmd_reg  <= done_cmd_next;
            rd_pend_reg   <= rd_pend_next;
        end
    end

    assign eng_clr_on = (state_reg == ST_BOOT) |
                        ((state_reg == ST_SWEEP) & (sweep_cmd_reg == CMD_CLEAR));

    // route: commands hit the current plane, generation writes the other, clear both
    assign cmd_we = fire & (cmd == CMD_WRITE) & in_grid;
    assign we_a   = (eng_we & (eng_clr_on | cur_b_reg)) | (cmd_we & ~cur_b_reg);
    assign we_b   = (eng_we & (eng_clr_on | ~cur_b_reg)) | (cmd_we & cur_b_reg);
    assign waddr  = eng_we ? eng_waddr : cmd_addr;
    assign wdata  = eng_we ? eng_wdata : cell_in;
    assign raddr  = busy ? eng_raddr : cmd_addr;
    assign src_rdata = cur_b_reg ? rd_b : rd_a;

    b1s1_gen_engine #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (eng_go),
        .clr_mode  (eng_clr),
        .src_rdata (src_rdata),
        .rd_addr   (eng_raddr),
        .wr_en     (eng_we),
        .wr_addr   (eng_waddr),
        .wr_data   (eng_wdata),
        .done      (eng_done)
    );

    b1s1_plane_ram #(
        .DEPTH (GRID_WIDTH * GRID_HEIGHT)
    ) u_plane_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_a)
    );

    b1s1_plane_ram #(
        .DEPTH (GRID_WIDTH * GRID_HEIGHT)
    ) u_plane_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_b)
    );

    assign done     = done_reg;
    assign done_cmd = done_cmd_reg;
    assign cell_out = rd_pend_reg & src_rdata;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown during sweep");

    a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == CMD_READ)) |=> (done && (done_cmd == CMD_READ)))
        else $error("read result missing");

    a_cell_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        cell_out |-> (done && (done_cmd == CMD_READ)))
        else $error("cell_out high outside read");

    a_eng_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        eng_we |-> busy)
        else $error("sweep write while idle");

endmodule

`default_nettype wire

FILE: verif/b1s1_cellular_automaton_step_test.sv
`timescale 1ns / 1ps

module b1s1_cellular_automaton_step_test;
    import b1s1_pkg::*;

    localparam int GRID_W      = DEF_GRID_WIDTH;
    localparam int GRID_H      = DEF_GRID_HEIGHT;
    localparam int CELLS       = GRID_W * GRID_H;
    localparam int STALL_LIMIT = 6 * (CELLS + 16);
    localparam int DRAIN_WAIT  = 20;

    typedef struct packed {
        logic cell_val;
        cmd_t op;
    } outcome_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic [CMD_W-1:0] cmd;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             cell_in;
    logic             busy;
    logic             done;
    logic             cell_out;
    logic [CMD_W-1:0] done_cmd;

    bit [CELLS-1:0] life_plane [0:1];
    bit             active_plane;
    outcome_t       pending_outcomes[$];
    int             error_count;
    int             items_sent;
    int             stall_cycles;
    bit             idle_enable;

    b1s1_cellular_automaton_step dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int cell_at(int c, int r);
        return c * GRID_H + r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    task automatic step_generation();
        int n;
        bit dst_plane;
        dst_plane = !active_plane;
        for (int c = 1; c < GRID_W - 1; c++)
        begin
            for (int r = 1; r < GRID_H - 1; r++)
            begin
                n = 0;
                for (int dc = -1; dc <= 1; dc++)
                begin
                    for (int dr = -1; dr <= 1; dr++)
                    begin
                        if (dc != 0 || dr != 0)
                            n += life_plane[active_plane][cell_at(c + dc, r + dr)];
                    end
                end
                life_plane[dst_plane][cell_at(c, r)] = (n == 1);
            end
        end
        active_plane = dst_plane;
    endtask

    task automatic predict_item(cmd_t op, int c, int r, bit v);
        outcome_t want;
        bit       in_grid;
        want.op       = op;
        want.cell_val = 1'b0;
        in_grid       = (c < GRID_W) && (r < GRID_H);
        case (op)
            CMD_CLEAR:
            begin
                life_plane[0] = '0;
                life_plane[1] = '0;
            end
            CMD_WRITE:
            begin
                if (in_grid)
                    life_plane[active_plane][cell_at(c, r)] = v;
            end
            CMD_READ:
            begin
                if (in_grid)
                    want.cell_val = life_plane[active_plane][cell_at(c, r)];
            end
            default:
                step_generation();
        endcase
        pending_outcomes.push_back(want);
    endtask

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_outcomes.size() == 0)
                    report_mismatch("result with no item pending", done_cmd, 0);
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (done_cmd !== want.op)
                        report_mismatch("done_cmd", done_cmd, want.op);
                    if (cell_out !== want.cell_val)
                        report_mismatch("cell_out", cell_out, want.cell_val);
                end
            end
            if (start && !busy)
                predict_item(cmd, col, row, cell_in);
        end
    end

    always @(posedge clk)
    begin
        if (done || (start && !busy))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("b1s1_cellular_automaton_step regression: fail");
            $finish;
        end
    end

    task automatic send_item(cmd_t op, int c, int r, bit v);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        cmd     <= op;
        col     <= c[COL_W-1:0];
        row     <= r[ROW_W-1:0];
        cell_in <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic test_reset_state();
        send_item(CMD_CLEAR, 0, 0, 1'b0);
        send_item(CMD_READ, 0, 0, 1'b0);
        send_item(CMD_READ, GRID_W - 1, GRID_H - 1, 1'b1);
        send_item(CMD_GEN, GRID_W - 1, GRID_H - 1, 1'b1);
        send_item(CMD_READ, 64, 32, 1'b0);
    endtask

    task automatic test_corners();
        send_item(CMD_WRITE, 0, 0, 1'b1);
        send_item(CMD_WRITE, GRID_W - 1, GRID_H - 1, 1'b1);
        send_item(CMD_WRITE, 0, GRID_H - 1, 1'b1);
        send_item(CMD_WRITE, GRID_W - 1, 0, 1'b1);
        send_item(CMD_READ, 0, 0, 1'b0);
        send_item(CMD_READ, GRID_W - 1, GRID_H - 1, 1'b0);
        send_item(CMD_READ, 0, GRID_H - 1, 1'b0);
        send_item(CMD_READ, GRID_W - 1, 0, 1'b0);
    endtask

    // border cells of the destination plane must keep their contents
    task automatic test_border_hold();
        send_item(CMD_WRITE, 0, 5, 1'b1);
        send_item(CMD_GEN, 0, 0, 1'b0);
        send_item(CMD_READ, 1, 5, 1'b0);
        send_item(CMD_READ, 0, 5, 1'b0);
        send_item(CMD_GEN, 0, 0, 1'b0);
        send_item(CMD_READ, 0, 5, 1'b0);
        send_item(CMD_WRITE, 0, 5, 1'b0);
    endtask

    // clear leaves the current-plane selection alone
    task automatic test_clear_keeps_plane();
        send_item(CMD_CLEAR, 3, 3, 1'b1);
        send_item(CMD_READ, GRID_W - 1, GRID_H - 1, 1'b0);
        send_item(CMD_WRITE, 10, 10, 1'b1);
        send_item(CMD_GEN, 0, 0, 1'b0);
        send_item(CMD_READ, 11, 11, 1'b0);
    endtask

    task automatic test_random_traffic(int target);
        int base_c;
        int base_r;
        int pick;
        int stop_at;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                base_c = $urandom_range(0, GRID_W - 1);
                base_r = $urandom_range(0, GRID_H - 1);
                repeat ($urandom_range(1, 5))
                    send_item(CMD_WRITE, (base_c + $urandom_range(0, 4)) % GRID_W,
                              (base_r + $urandom_range(0, 4)) % GRID_H,
                              $urandom_range(0, 3) != 0);
                send_item(CMD_GEN, $urandom_range(0, GRID_W - 1),
                          $urandom_range(0, GRID_H - 1), $urandom_range(0, 1));
                if ($urandom_range(0, 4) == 0)
                    send_item(CMD_GEN, 0, 0, 1'b0);
                repeat ($urandom_range(2, 5))
                    send_item(CMD_READ, (base_c + GRID_W - 1 + $urandom_range(0, 6)) % GRID_W,
                              (base_r + GRID_H - 1 + $urandom_range(0, 6)) % GRID_H,
                              $urandom_range(0, 1));
            end
            else
            begin
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    send_item(CMD_CLEAR, $urandom_range(0, GRID_W - 1),
                              $urandom_range(0, GRID_H - 1), $urandom_range(0, 1));
                else if (pick < 7)
                    send_item(CMD_WRITE, $urandom_range(0, GRID_W - 1),
                              $urandom_range(0, GRID_H - 1), $urandom_range(0, 1));
                else if (pick < 13)
                    send_item(CMD_READ, $urandom_range(0, GRID_W - 1),
                              $urandom_range(0, GRID_H - 1), $urandom_range(0, 1));
                else
                    send_item(CMD_GEN, $urandom_range(0, GRID_W - 1),
                              $urandom_range(0, GRID_H - 1), $urandom_range(0, 1));
            end
        end
    endtask

    task automatic test_back_to_back();
        idle_enable = 1'b0;
        send_item(CMD_WRITE, 20, 20, 1'b1);
        send_item(CMD_WRITE, 21, 20, 1'b1);
        send_item(CMD_READ, 20, 20, 1'b0);
        send_item(CMD_GEN, 0, 0, 1'b0);
        send_item(CMD_READ, 19, 19, 1'b0);
        send_item(CMD_READ, 20, 21, 1'b0);
        send_item(CMD_WRITE, 22, 22, 1'b0);
        send_item(CMD_READ, 22, 22, 1'b0);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_CLEAR;
        col          = '0;
        row          = '0;
        cell_in      = 1'b0;
        error_count  = 0;
        items_sent   = 0;
        stall_cycles = 0;
        idle_enable  = 1'b1;
        active_plane = 1'b0;
        life_plane[0] = '0;
        life_plane[1] = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_corners();
        test_border_hold();
        test_clear_keeps_plane();
        test_random_traffic(70);
        test_back_to_back();

        @(negedge clk);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("b1s1_cellular_automaton_step regression: pass");
        else
            $display("b1s1_cellular_automaton_step regression: fail");
        $finish;
    end

endmodule
